[rtl/core/hwts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hwts_pkg;

    localparam int VW       = 32;
    localparam int PW       = 68;
    localparam int IDX_W    = 6;
    localparam int SLEN_W   = 7;
    localparam int HOR_W    = 5;
    localparam int STEP_W   = 4;
    localparam int W_W      = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [SLEN_W-1:0] SEASON_MAX  = 7'd64;
    localparam logic [HOR_W-1:0]  HORIZON_MAX = 5'd16;
    localparam logic [W_W-1:0]    W_ONE       = 17'd65536;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [2:0] {
        CMD_OBS_FULL = 3'd0,
        CMD_OBS_ONE  = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_LOAD     = 3'd3,
        CMD_RESTART  = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA       = 3'd0,
        REG_BETA        = 3'd1,
        REG_GAMMA       = 3'd2,
        REG_MULT        = 3'd3,
        REG_HORIZON     = 3'd4,
        REG_SEASON_LEN  = 3'd5,
        REG_START_LEVEL = 3'd6,
        REG_START_TREND = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RDSP,
        ST_GETSP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_BL_A,
        ST_BL_B,
        ST_BL_C,
        ST_FC_RD,
        ST_FC_MUL,
        ST_FC_OUT,
        ST_COMMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_LEVEL,
        PH_TREND,
        PH_SEASON
    } t_phase;

    typedef struct packed {
        logic                 start;
        logic signed [VW-1:0] num;
        logic signed [VW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic                 fault;
        logic signed [VW-1:0] quot;
    } t_div_rsp;

    // Clamp a wide two's complement value to the signed value range.
    function automatic logic signed [VW-1:0] sat70(input logic signed [69:0] x);
        logic [69-VW+1:0] top;
        top = x[69:VW-1];
        if (top == '0 || top == '1) begin
            return x[VW-1:0];
        end
        return x[69] ? VMIN : VMAX;
    endfunction

endpackage

`default_nettype wire

[rtl/core/hwts_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface hwts_obs_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          command;
    logic signed [hwts_pkg::VW-1:0]      observation;
    logic [hwts_pkg::IDX_W-1:0]          entry_index;
    logic signed [hwts_pkg::VW-1:0]      entry_value;

    modport source (output valid, command, observation, entry_index, entry_value,
                    input ready);
    modport sink (input valid, command, observation, entry_index, entry_value,
                  output ready);
endinterface

interface hwts_fc_if;
    logic                                valid;
    logic                                ready;
    logic [hwts_pkg::STEP_W-1:0]         horizon_step;
    logic signed [hwts_pkg::VW-1:0]      forecast;
    logic                                last;
    logic                                div_fault;

    modport source (output valid, horizon_step, forecast, last, div_fault,
                    input ready);
    modport sink (input valid, horizon_step, forecast, last, div_fault,
                  output ready);
endinterface

interface hwts_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hwts_pkg::CFG_IDX_W-1:0]      index;
    logic [hwts_pkg::VW-1:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/holt_winters_triple_smoother_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Holt-Winters triple exponential smoother, additive or multiplicative, in signed
// Q16.16 with unsigned Q1.16 weights. Load and restart commands finish in the cycle
// they are accepted. An observation or forecast tick is handled one at a time: it
// folds the season pointer when the season length was shrunk and reads the season
// slot, then for observations runs three blends (level, trend, season) on one
// shared 34x34 multiplier, and in multiplicative mode two divisions on a bit-serial
// divider; every forecast then passes through the read, multiply-or-add and output
// states, using the shared multiplier in multiplicative mode, and waits in the output
// state while the sink stalls. The block is not ready while it works on an item;
// the last forecast may still wait in the output register when it is.

module holt_winters_triple_smoother_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    hwts_obs_if.sink        i_obs,
    hwts_fc_if.source       o_fc,
    hwts_cfg_if.sink        i_cfg
);

    localparam int VW = hwts_pkg::VW;
    localparam int PW = hwts_pkg::PW;

    // Configuration registers.
    logic [hwts_pkg::W_W-1:0]    r_alpha, r_beta, r_gamma;
    logic                        r_mult;
    logic [hwts_pkg::HOR_W-1:0]  r_horizon;
    logic [hwts_pkg::SLEN_W-1:0] r_slen_cfg;
    logic signed [VW-1:0]        r_start_level, r_start_trend;

    // Model state.
    logic signed [VW-1:0]        r_lvl, r_trd;
    logic [hwts_pkg::IDX_W-1:0]  r_pos;
    logic signed [VW-1:0]        r_mem [hwts_pkg::SEASON_MAX];

    // Working registers.
    hwts_pkg::t_state            r_state, n_state;
    hwts_pkg::t_phase            r_phase;
    hwts_pkg::t_cmd              r_cmd;
    logic signed [VW-1:0]        r_y, r_sp, r_sdat, r_q, r_nl, r_nt, r_ns;
    logic [hwts_pkg::IDX_W-1:0]  r_p, r_k;
    logic [hwts_pkg::STEP_W-1:0] r_j;
    logic [hwts_pkg::HOR_W-1:0]  r_hlim;
    logic signed [37:0]          r_base;
    logic signed [PW-1:0]        r_prod, r_acc;
    logic                        r_fault;

    logic                        r_out_valid;
    logic [hwts_pkg::STEP_W-1:0] r_out_step;
    logic signed [VW-1:0]        r_out_fc;
    logic                        r_out_last;
    logic                        r_out_fault;

    // Combinational signals.
    logic                        obs_acc, cfg_acc, out_acc, slot_free, fc_last;
    logic [hwts_pkg::SLEN_W-1:0] slen;
    logic [hwts_pkg::HOR_W-1:0]  hor;
    logic [hwts_pkg::W_W-1:0]    wsel, winv;
    logic signed [VW:0]          bx, by;
    logic signed [33:0]          mul_a, mul_b;
    logic signed [PW-1:0]        prod;
    logic signed [PW:0]          bsum;
    logic signed [VW-1:0]        bres, base_sat, fc_val;
    logic [hwts_pkg::IDX_W-1:0]  rd_addr;
    logic [hwts_pkg::SLEN_W-1:0] k_inc;
    hwts_pkg::t_div_req          div_req;
    hwts_pkg::t_div_rsp          div_rsp;

    function automatic logic [hwts_pkg::W_W-1:0] clamp_w(input logic [hwts_pkg::W_W-1:0] w);
        return (w > hwts_pkg::W_ONE) ? hwts_pkg::W_ONE : w;
    endfunction

    assign obs_acc   = i_obs.valid && i_obs.ready;
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign out_acc   = o_fc.valid && o_fc.ready;
    assign slot_free = !r_out_valid || o_fc.ready;
    assign fc_last   = ({1'b0, r_j} + 1'b1) == r_hlim;
    assign k_inc     = {1'b0, r_k} + 1'b1;

    always_comb begin
        if (r_slen_cfg == '0) begin
            slen = 7'd1;
        end else if (r_slen_cfg > hwts_pkg::SEASON_MAX) begin
            slen = hwts_pkg::SEASON_MAX;
        end else begin
            slen = r_slen_cfg;
        end
        if (r_horizon == '0) begin
            hor = 5'd1;
        end else if (r_horizon > hwts_pkg::HORIZON_MAX) begin
            hor = hwts_pkg::HORIZON_MAX;
        end else begin
            hor = r_horizon;
        end
    end

    // Blend operands: weight, new-sample term and carried term for each phase.
    always_comb begin
        case (r_phase)
            hwts_pkg::PH_LEVEL: begin
                wsel = clamp_w(r_alpha);
                bx   = r_mult ? (VW+1)'(r_q) : (VW+1)'(r_y) - (VW+1)'(r_sp);
                by   = (VW+1)'(r_lvl) + (VW+1)'(r_trd);
            end
            hwts_pkg::PH_TREND: begin
                wsel = clamp_w(r_beta);
                bx   = (VW+1)'(r_nl) - (VW+1)'(r_lvl);
                by   = (VW+1)'(r_trd);
            end
            hwts_pkg::PH_SEASON: begin
                wsel = clamp_w(r_gamma);
                bx   = r_mult ? (VW+1)'(r_q) : (VW+1)'(r_y) - (VW+1)'(r_nl);
                by   = (VW+1)'(r_sp);
            end
            default: begin
                wsel = '0;
                bx   = '0;
                by   = '0;
            end
        endcase
        winv = hwts_pkg::W_ONE - wsel;
    end

    assign prod     = mul_a * mul_b;
    assign bsum     = (PW+1)'(r_acc) + (PW+1)'(r_prod);
    assign bres     = hwts_pkg::sat70(70'(bsum >>> 16));
    assign base_sat = hwts_pkg::sat70(70'(r_base));
    assign fc_val   = r_mult ? hwts_pkg::sat70(70'(r_prod >>> 16))
                             : hwts_pkg::sat70(70'(r_prod));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            hwts_pkg::ST_IDLE: begin
                if (obs_acc && (i_obs.command == hwts_pkg::CMD_OBS_FULL
                        || i_obs.command == hwts_pkg::CMD_OBS_ONE
                        || i_obs.command == hwts_pkg::CMD_TICK)) begin
                    n_state = hwts_pkg::ST_REDUCE;
                end
            end
            hwts_pkg::ST_REDUCE: begin
                if ({1'b0, r_p} < slen) begin
                    n_state = hwts_pkg::ST_RDSP;
                end
            end
            hwts_pkg::ST_RDSP: n_state = hwts_pkg::ST_GETSP;
            hwts_pkg::ST_GETSP: begin
                if (r_cmd == hwts_pkg::CMD_TICK) begin
                    n_state = hwts_pkg::ST_FC_RD;
                end else if (r_mult) begin
                    n_state = hwts_pkg::ST_DIV_GO;
                end else begin
                    n_state = hwts_pkg::ST_BL_A;
                end
            end
            hwts_pkg::ST_DIV_GO: n_state = hwts_pkg::ST_DIV_WAIT;
            hwts_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = hwts_pkg::ST_BL_A;
                end
            end
            hwts_pkg::ST_BL_A: n_state = hwts_pkg::ST_BL_B;
            hwts_pkg::ST_BL_B: n_state = hwts_pkg::ST_BL_C;
            hwts_pkg::ST_BL_C: begin
                case (r_phase)
                    hwts_pkg::PH_LEVEL: n_state = hwts_pkg::ST_BL_A;
                    hwts_pkg::PH_TREND: begin
                        n_state = r_mult ? hwts_pkg::ST_DIV_GO : hwts_pkg::ST_BL_A;
                    end
                    default: n_state = hwts_pkg::ST_FC_RD;
                endcase
            end
            hwts_pkg::ST_FC_RD:  n_state = hwts_pkg::ST_FC_MUL;
            hwts_pkg::ST_FC_MUL: n_state = hwts_pkg::ST_FC_OUT;
            hwts_pkg::ST_FC_OUT: begin
                if (slot_free) begin
                    n_state = fc_last ? hwts_pkg::ST_COMMIT : hwts_pkg::ST_FC_RD;
                end
            end
            hwts_pkg::ST_COMMIT: n_state = hwts_pkg::ST_IDLE;
            default: n_state = hwts_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        rd_addr       = r_k;
        div_req.start = 1'b0;
        div_req.num   = r_y;
        div_req.den   = (r_phase == hwts_pkg::PH_LEVEL) ? r_sp : r_nl;
        case (r_state)
            hwts_pkg::ST_RDSP: rd_addr = r_p;
            hwts_pkg::ST_DIV_GO: div_req.start = 1'b1;
            hwts_pkg::ST_BL_A: begin
                mul_a = 34'(wsel);
                mul_b = 34'(bx);
            end
            hwts_pkg::ST_BL_B: begin
                mul_a = 34'(winv);
                mul_b = 34'(by);
            end
            hwts_pkg::ST_FC_MUL: begin
                mul_a = 34'(base_sat);
                mul_b = 34'(r_sdat);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    hwts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha       <= 17'd32768;
            r_beta        <= 17'd32768;
            r_gamma       <= 17'd32768;
            r_mult        <= 1'b0;
            r_horizon     <= 5'd1;
            r_slen_cfg    <= 7'd1;
            r_start_level <= '0;
            r_start_trend <= '0;
        end else if (cfg_acc) begin
            case (hwts_pkg::t_reg'(i_cfg.index))
                hwts_pkg::REG_ALPHA:       r_alpha       <= i_cfg.data[hwts_pkg::W_W-1:0];
                hwts_pkg::REG_BETA:        r_beta        <= i_cfg.data[hwts_pkg::W_W-1:0];
                hwts_pkg::REG_GAMMA:       r_gamma       <= i_cfg.data[hwts_pkg::W_W-1:0];
                hwts_pkg::REG_MULT:        r_mult        <= i_cfg.data[0];
                hwts_pkg::REG_HORIZON:     r_horizon     <= i_cfg.data[hwts_pkg::HOR_W-1:0];
                hwts_pkg::REG_SEASON_LEN:  r_slen_cfg    <= i_cfg.data[hwts_pkg::SLEN_W-1:0];
                hwts_pkg::REG_START_LEVEL: r_start_level <= i_cfg.data;
                hwts_pkg::REG_START_TREND: r_start_trend <= i_cfg.data;
                default: r_mult <= r_mult;
            endcase
        end
    end

    // Season table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == hwts_pkg::ST_IDLE && obs_acc
                && i_obs.command == hwts_pkg::CMD_LOAD) begin
            r_mem[i_obs.entry_index] <= i_obs.entry_value;
        end else if (r_state == hwts_pkg::ST_COMMIT && r_cmd != hwts_pkg::CMD_TICK) begin
            r_mem[r_p] <= r_ns;
        end
        r_sdat <= r_mem[rd_addr];
    end

    // Control state and model state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hwts_pkg::ST_IDLE;
            r_lvl       <= '0;
            r_trd       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hwts_pkg::ST_FC_OUT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == hwts_pkg::ST_IDLE && obs_acc
                    && i_obs.command == hwts_pkg::CMD_RESTART) begin
                r_lvl <= r_start_level;
                r_trd <= r_start_trend;
                r_pos <= (slen == 7'd1) ? 6'd0 : 6'd1;
            end
            if (r_state == hwts_pkg::ST_COMMIT) begin
                if (r_cmd != hwts_pkg::CMD_TICK) begin
                    r_lvl <= r_nl;
                    r_trd <= r_nt;
                end
                r_pos <= (({1'b0, r_p} + 1'b1) == slen) ? '0 : r_p + 1'b1;
            end
        end
    end

    // Working datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            hwts_pkg::ST_IDLE: begin
                r_cmd   <= hwts_pkg::t_cmd'(i_obs.command);
                r_y     <= i_obs.observation;
                r_p     <= r_pos;
                r_fault <= 1'b0;
                r_phase <= hwts_pkg::PH_LEVEL;
                r_hlim  <= (i_obs.command == hwts_pkg::CMD_OBS_FULL) ? hor : 5'd1;
            end
            hwts_pkg::ST_REDUCE: begin
                if ({1'b0, r_p} >= slen) begin
                    r_p <= r_p - slen[hwts_pkg::IDX_W-1:0];
                end
            end
            hwts_pkg::ST_GETSP: begin
                r_sp   <= r_sdat;
                r_base <= 38'(r_lvl);
                r_k    <= r_p;
                r_j    <= '0;
            end
            hwts_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    r_q     <= div_rsp.quot;
                    r_fault <= r_fault | div_rsp.fault;
                end
            end
            hwts_pkg::ST_BL_A: r_prod <= prod;
            hwts_pkg::ST_BL_B: begin
                r_acc  <= r_prod;
                r_prod <= prod;
            end
            hwts_pkg::ST_BL_C: begin
                case (r_phase)
                    hwts_pkg::PH_LEVEL: begin
                        r_nl    <= bres;
                        r_phase <= hwts_pkg::PH_TREND;
                    end
                    hwts_pkg::PH_TREND: begin
                        r_nt    <= bres;
                        r_phase <= hwts_pkg::PH_SEASON;
                    end
                    default: r_ns <= bres;
                endcase
            end
            hwts_pkg::ST_FC_RD: r_base <= r_base + 38'(r_trd);
            hwts_pkg::ST_FC_MUL: begin
                r_prod <= r_mult ? prod : PW'(base_sat) + PW'(r_sdat);
            end
            hwts_pkg::ST_FC_OUT: begin
                if (slot_free) begin
                    r_out_step  <= r_j;
                    r_out_fc    <= fc_val;
                    r_out_last  <= fc_last;
                    r_out_fault <= r_fault;
                    r_j         <= r_j + 1'b1;
                    r_k         <= (k_inc == slen) ? '0 : k_inc[hwts_pkg::IDX_W-1:0];
                end
            end
            default: r_base <= r_base;
        endcase
    end

    assign i_obs.ready     = (r_state == hwts_pkg::ST_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_fc.valid      = r_out_valid;
    assign o_fc.horizon_step = r_out_step;
    assign o_fc.forecast   = r_out_fc;
    assign o_fc.last       = r_out_last;
    assign o_fc.div_fault  = r_out_fault;

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == hwts_pkg::ST_DIV_WAIT)
        else $error("divider finished while the sequencer was not waiting for it");

    a_slot_in_season: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hwts_pkg::ST_FC_RD |-> {1'b0, r_k} < slen)
        else $error("forecast season slot beyond the season length");

    a_step_in_horizon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hwts_pkg::ST_FC_OUT |-> {1'b0, r_j} < r_hlim)
        else $error("forecast step beyond the horizon");

    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hwts_pkg::ST_COMMIT |=> r_state == hwts_pkg::ST_IDLE)
        else $error("commit did not return to idle");

endmodule

`default_nettype wire

[rtl/core/hwts_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module hwts_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  hwts_pkg::t_div_req   i_req,
    output hwts_pkg::t_div_rsp   o_rsp
);

    localparam int QW = hwts_pkg::VW + 16;
    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

    logic                     r_busy;
    logic                     r_done;
    logic                     r_zero;
    logic                     r_neg;
    logic [CW-1:0]            r_cnt;
    logic [hwts_pkg::VW-1:0]  r_rem;
    logic [QW-1:0]            r_quo;
    logic [hwts_pkg::VW-1:0]  r_den;
    logic signed [hwts_pkg::VW-1:0] r_zq;

    logic [hwts_pkg::VW:0]    rem_sh;
    logic                     take;
    logic [hwts_pkg::VW-1:0]  mag_n;
    logic [hwts_pkg::VW-1:0]  mag_d;
    logic signed [hwts_pkg::VW-1:0] quot_sat;

    assign rem_sh = {r_rem, r_quo[QW-1]};
    assign take   = rem_sh >= {1'b0, r_den};
    assign mag_n  = i_req.num[hwts_pkg::VW-1] ? (~i_req.num + 1'b1) : i_req.num;
    assign mag_d  = i_req.den[hwts_pkg::VW-1] ? (~i_req.den + 1'b1) : i_req.den;

    // The quotient magnitude can reach 2^47, so it is clamped to the signed range.
    always_comb begin
        if (r_neg) begin
            if (r_quo > QW'({1'b1, {(hwts_pkg::VW-1){1'b0}}})) begin
                quot_sat = hwts_pkg::VMIN;
            end else begin
                quot_sat = hwts_pkg::VW'(~r_quo + 1'b1);
            end
        end else begin
            if (r_quo > QW'(hwts_pkg::VMAX)) begin
                quot_sat = hwts_pkg::VMAX;
            end else begin
                quot_sat = r_quo[hwts_pkg::VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_zero <= (i_req.den == '0);
            r_neg  <= i_req.num[hwts_pkg::VW-1] ^ i_req.den[hwts_pkg::VW-1];
            r_rem  <= '0;
            r_quo  <= {mag_n, 16'd0};
            r_den  <= mag_d;
            if (i_req.num[hwts_pkg::VW-1]) begin
                r_zq <= hwts_pkg::VMIN;
            end else if (i_req.num == '0) begin
                r_zq <= '0;
            end else begin
                r_zq <= hwts_pkg::VMAX;
            end
        end else if (r_busy) begin
            r_rem <= take ? hwts_pkg::VW'(rem_sh - {1'b0, r_den})
                          : rem_sh[hwts_pkg::VW-1:0];
            r_quo <= {r_quo[QW-2:0], take};
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.fault = r_zero;
    assign o_rsp.quot  = r_zero ? r_zq : quot_sat;

endmodule

`default_nettype wire
